[design/pcrc_pkg.sv]
// Package: shared widths, register indexes, risk codes and configuration bundle.
`timescale 1ns / 1ps
package pcrc_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] REG_VEHICLE_SPEED    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ROAD_FRICTION    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_PEDESTRIAN_SPEED = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_TIME_HORIZON     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_HIGH_LIMIT       = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_MODERATE_LIMIT   = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_LOW_LIMIT        = 3'd6;

    localparam logic [2:0] RISK_CRITICAL = 3'd0;
    localparam logic [2:0] RISK_HIGH     = 3'd1;
    localparam logic [2:0] RISK_MODERATE = 3'd2;
    localparam logic [2:0] RISK_LOW      = 3'd3;
    localparam logic [2:0] RISK_NONE     = 3'd4;

    localparam logic signed [23:0] TIME_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] TIME_MIN = 24'sh800000;

    // product widths
    localparam int DistW = 16;
    localparam int DiffW = 21;
    localparam int NumW  = 49;
    localparam int DenW  = 42;
    localparam int DvdW  = NumW + 8;
    localparam int QuoW  = 24;

    typedef struct packed {
        logic [15:0]     vehicle_speed;
        logic [9:0]      road_friction;
        logic [15:0]     high_limit;
        logic [15:0]     moderate_limit;
        logic [15:0]     low_limit;
        logic [19:0]     travel;
        logic [27:0]     fric_scaled;
        logic [DenW-1:0] brake_term;
        logic [DenW-1:0] divisor;
    } pcrc_cfg_t;

endpackage

[design/pcrc_req_if.sv]
// Interface: pedestrian position channel.
`timescale 1ns / 1ps
interface pcrc_req_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] lateral_offset;
    logic signed [15:0] forward_depth;

    modport source (output valid, output lateral_offset, output forward_depth, input ready);
    modport sink (input valid, input lateral_offset, input forward_depth, output ready);
endinterface

[design/pcrc_rsp_if.sv]
// Interface: risk result channel.
`timescale 1ns / 1ps
interface pcrc_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] remaining_time;
    logic [2:0]         risk_class;
    logic               vehicle_stopped;

    modport source (output valid, output remaining_time, output risk_class,
                    output vehicle_stopped, input ready);
    modport sink (input valid, input remaining_time, input risk_class,
                  input vehicle_stopped, output ready);
endinterface

[design/pedestrian_collision_risk_classifier_unit.sv]
// Top level: pedestrian collision risk classifier.
// Usage: positions arrive on req (lateral_offset, forward_depth, Q8 metres) with
// valid/ready; one result per beat leaves on rsp (remaining_time Q8 s, risk_class,
// vehicle_stopped) in the same order. Settings are written on cfg_we/cfg_index/
// cfg_data while no beat is in flight; indexes past the last register are ignored.
// Throughput: one beat per cycle unless rsp stalls; the pipeline includes 16
// square-root stages and 25 divider stages, each advancing on a shared enable.
// Stall: while rsp holds a beat that is not taken, every stage holds and req.ready
// drops; nothing is lost or repeated.
// Reset: all valid bits clear, registers take their default settings; derived
// products are registered from the settings and so trail reset or a write.
`timescale 1ns / 1ps
module pedestrian_collision_risk_classifier_unit
    import pcrc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    pcrc_req_if.sink            req,
    pcrc_rsp_if.source          rsp,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    pcrc_cfg_t cfg;
    logic      en;

    logic               dist_vld;
    logic [DistW-1:0]   ped_dist;
    logic               diff_vld_reg;
    logic signed [DiffW-1:0] diff_reg;
    logic               prod_vld_reg;
    logic signed [NumW-1:0] prod_reg;
    logic               num_vld_reg;
    logic signed [NumW-1:0] num_reg;
    logic               mag_vld_reg;
    logic [NumW-1:0]    mag_reg;
    logic               neg_reg;

    logic               div_vld;
    logic [QuoW-1:0]    quo;
    logic               rem_nz;
    logic               div_neg;
    logic               ovf;

    logic               t_vld_reg;
    logic signed [23:0] t_reg;
    logic               stop_reg;
    logic signed [23:0] t_next;
    logic [QuoW:0]      m;

    logic               out_vld_reg;
    logic signed [23:0] out_t_reg;
    logic [2:0]         out_cls_reg;
    logic               out_stop_reg;
    logic [2:0]         cls_next;
    logic [23:0]        t_u;

    assign en        = !out_vld_reg || rsp.ready;
    assign req.ready = en;

    pcrc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcrc_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req.valid),
        .x         (req.lateral_offset),
        .y         (req.forward_depth),
        .out_valid (dist_vld),
        .ped_dist  (ped_dist)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= $signed(DiffW'(ped_dist)) - $signed(DiffW'(cfg.travel));
            prod_reg <= NumW'(diff_reg * $signed({1'b0, cfg.fric_scaled}));
            num_reg  <= prod_reg - $signed(NumW'(cfg.brake_term));
            neg_reg  <= num_reg[NumW-1];
            mag_reg  <= num_reg[NumW-1] ? NumW'(-num_reg) : NumW'(num_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_vld_reg <= 1'b0;
            prod_vld_reg <= 1'b0;
            num_vld_reg  <= 1'b0;
            mag_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            diff_vld_reg <= dist_vld;
            prod_vld_reg <= diff_vld_reg;
            num_vld_reg  <= prod_vld_reg;
            mag_vld_reg  <= num_vld_reg;
        end
    end

    pcrc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mag_vld_reg),
        .mag       (mag_reg),
        .neg       (neg_reg),
        .divisor   (cfg.divisor),
        .out_valid (div_vld),
        .quo       (quo),
        .rem_nz    (rem_nz),
        .out_neg   (div_neg),
        .ovf       (ovf)
    );

    // stopped vehicle and zero friction first; else floor toward minus infinity, then saturate
    always_comb
    begin
        m = {1'b0, quo} + (QuoW+1)'(rem_nz);
        priority if (cfg.vehicle_speed == 16'd0)
            t_next = TIME_MAX;
        else if (cfg.road_friction == 10'd0)
            t_next = TIME_MIN;
        else if (!div_neg)
            t_next = (ovf || quo[QuoW-1]) ? TIME_MAX : $signed(quo);
        else
            t_next = (ovf || m > (QuoW+1)'(25'd8388608)) ? TIME_MIN : $signed(24'(-m));
    end

    always_comb
    begin
        t_u = t_reg;
        priority if (t_reg[23])
            cls_next = RISK_CRITICAL;
        else if (t_u < 24'(cfg.high_limit))
            cls_next = RISK_HIGH;
        else if (t_u < 24'(cfg.moderate_limit))
            cls_next = RISK_MODERATE;
        else if (t_u < 24'(cfg.low_limit))
            cls_next = RISK_LOW;
        else
            cls_next = RISK_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg        <= t_next;
            stop_reg     <= (cfg.vehicle_speed == 16'd0);
            out_t_reg    <= t_reg;
            out_cls_reg  <= cls_next;
            out_stop_reg <= stop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            t_vld_reg   <= div_vld;
            out_vld_reg <= t_vld_reg;
        end
    end

    assign rsp.valid           = out_vld_reg;
    assign rsp.remaining_time  = out_t_reg;
    assign rsp.risk_class      = out_cls_reg;
    assign rsp.vehicle_stopped = out_stop_reg;

    a_stopped_none: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.vehicle_stopped |->
            rsp.risk_class == RISK_NONE && rsp.remaining_time == TIME_MAX)
        else $error("stopped beat without saturated time and class none");

    a_critical_sign: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ((rsp.risk_class == RISK_CRITICAL) == rsp.remaining_time[23]))
        else $error("critical class disagrees with sign of time");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> rsp.valid && !rsp.ready)
        else $error("input held off without an output stall");

endmodule

[design/pcrc_cfg.sv]
// Configuration registers and the products derived from them.
`timescale 1ns / 1ps
module pcrc_cfg
    import pcrc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output pcrc_cfg_t           cfg
);

    logic [15:0] speed_reg;
    logic [9:0]  fric_reg;
    logic [11:0] ped_reg;
    logic [7:0]  horizon_reg;
    logic [15:0] high_reg;
    logic [15:0] moderate_reg;
    logic [15:0] low_reg;

    logic [19:0]     travel_reg;
    logic [27:0]     kf_reg;
    logic [31:0]     ss_reg;
    logic [25:0]     fs_reg;
    logic [DenW-1:0] s2_reg;
    logic [DenW-1:0] den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg    <= 16'd12800;
            fric_reg     <= 10'd179;
            ped_reg      <= 12'd0;
            horizon_reg  <= 8'd0;
            high_reg     <= 16'd128;
            moderate_reg <= 16'd256;
            low_reg      <= 16'd384;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VEHICLE_SPEED:    speed_reg    <= cfg_data;
                REG_ROAD_FRICTION:    fric_reg     <= cfg_data[9:0];
                REG_PEDESTRIAN_SPEED: ped_reg      <= cfg_data[11:0];
                REG_TIME_HORIZON:     horizon_reg  <= cfg_data[7:0];
                REG_HIGH_LIMIT:       high_reg     <= cfg_data;
                REG_MODERATE_LIMIT:   moderate_reg <= cfg_data;
                REG_LOW_LIMIT:        low_reg      <= cfg_data;
                default:              ;
            endcase
        end
    end

    // derived products, registered; the brake term and divisor build on registered intermediates
    always_ff @(posedge clk)
    begin
        travel_reg <= 20'(ped_reg * 20'(horizon_reg));
        kf_reg     <= 28'(28'd158922 * 28'(fric_reg));
        ss_reg     <= 32'(speed_reg * 32'(speed_reg));
        fs_reg     <= 26'(26'(fric_reg) * 26'(speed_reg));
        s2_reg     <= DenW'(DenW'(625) * DenW'(ss_reg));
        den_reg    <= DenW'(DenW'(44145) * DenW'(fs_reg));
    end

    assign cfg.vehicle_speed  = speed_reg;
    assign cfg.road_friction  = fric_reg;
    assign cfg.high_limit     = high_reg;
    assign cfg.moderate_limit = moderate_reg;
    assign cfg.low_limit      = low_reg;
    assign cfg.travel         = travel_reg;
    assign cfg.fric_scaled    = kf_reg;
    assign cfg.brake_term     = s2_reg;
    assign cfg.divisor        = den_reg;

endmodule

[design/pcrc_dist.sv]
// Distance pipeline: squares, sum and a one-bit-pair-per-stage integer square root.
`timescale 1ns / 1ps
module pcrc_dist
    import pcrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [15:0] x,
    input  logic signed [15:0] y,
    output logic               out_valid,
    output logic [DistW-1:0]   ped_dist
);

    localparam int Steps = 16;

    logic [30:0] xx_reg;
    logic [30:0] yy_reg;
    logic        sq_vld_reg;
    logic [31:0] v_reg   [0:Steps];
    logic [31:0] res_reg [0:Steps];
    logic        vld_reg [0:Steps];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg     <= 31'(x * x);
            yy_reg     <= 31'(y * y);
            v_reg[0]   <= 32'(xx_reg) + 32'(yy_reg);
            res_reg[0] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_vld_reg <= in_valid;
            vld_reg[0] <= sq_vld_reg;
        end
    end

    for (genvar k = 0; k < Steps; k++)
    begin : g_root
        localparam logic [31:0] Bit = 32'd1 << (30 - 2 * k);
        logic [31:0] trial;
        logic [31:0] v_next;
        logic [31:0] res_next;

        always_comb
        begin
            trial = res_reg[k] + Bit;
            if (v_reg[k] >= trial)
            begin
                v_next   = v_reg[k] - trial;
                res_next = (res_reg[k] >> 1) + Bit;
            end
            else
            begin
                v_next   = v_reg[k];
                res_next = res_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k+1]   <= v_next;
                res_reg[k+1] <= res_next;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_reg[k];
        end
    end

    assign out_valid = vld_reg[Steps];
    assign ped_dist  = res_reg[Steps][DistW-1:0];

endmodule

[design/pcrc_div.sv]
// Divider pipeline: overflow check, then one quotient bit per stage.
`timescale 1ns / 1ps
module pcrc_div
    import pcrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NumW-1:0]   mag,
    input  logic              neg,
    input  logic [DenW-1:0]   divisor,
    output logic              out_valid,
    output logic [QuoW-1:0]   quo,
    output logic              rem_nz,
    output logic              out_neg,
    output logic              ovf
);

    localparam int Stages = QuoW + 1;
    localparam int CmpW   = DenW + QuoW;

    logic [DvdW-1:0] r_reg   [1:Stages];
    logic [QuoW-1:0] q_reg   [1:Stages];
    logic            neg_reg [1:Stages];
    logic            ovf_reg [1:Stages];
    logic            vld_reg [1:Stages];

    for (genvar j = 0; j < Stages; j++)
    begin : g_step
        localparam int Sh = QuoW - j;
        logic [DvdW-1:0] r_src;
        logic [QuoW-1:0] q_src;
        logic            neg_src;
        logic            ovf_src;
        logic            vld_src;
        logic [CmpW-1:0] dsh;
        logic            ge;

        if (j == 0)
        begin : g_head
            assign r_src   = {mag, 8'd0};
            assign q_src   = '0;
            assign neg_src = neg;
            assign ovf_src = 1'b0;
            assign vld_src = in_valid;
        end
        else
        begin : g_body
            assign r_src   = r_reg[j];
            assign q_src   = q_reg[j];
            assign neg_src = neg_reg[j];
            assign ovf_src = ovf_reg[j];
            assign vld_src = vld_reg[j];
        end

        assign dsh = CmpW'(divisor) << Sh;
        assign ge  = CmpW'(r_src) >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[j+1] <= neg_src;
                if (j == 0)
                begin
                    r_reg[j+1]   <= r_src;
                    q_reg[j+1]   <= q_src;
                    ovf_reg[j+1] <= ge;
                end
                else
                begin
                    r_reg[j+1]   <= ge ? DvdW'(CmpW'(r_src) - dsh) : r_src;
                    q_reg[j+1]   <= q_src | (QuoW'(ge) << Sh);
                    ovf_reg[j+1] <= ovf_src;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j+1] <= 1'b0;
            else if (en)
                vld_reg[j+1] <= vld_src;
        end
    end

    assign out_valid = vld_reg[Stages];
    assign quo       = q_reg[Stages];
    assign rem_nz    = |r_reg[Stages];
    assign out_neg   = neg_reg[Stages];
    assign ovf       = ovf_reg[Stages];

endmodule

[verif/tb.sv]
// Testbench: random and directed positions against a built-in risk predictor.
`timescale 1ns / 1ps
module tb;
    import pcrc_pkg::*;

    localparam int LatencyWait = 64;
    localparam int CycleLimit  = 600000;
    localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [15:0] lateral_offset;
        logic signed [15:0] forward_depth;
    } position_t;

    typedef struct packed {
        logic signed [23:0] remaining_time;
        logic [2:0]         risk_class;
        logic               vehicle_stopped;
    } risk_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    pcrc_req_if req ();
    pcrc_rsp_if rsp ();

    pedestrian_collision_risk_classifier_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow settings
    longint vspeed, friction, ped_speed, horizon, lim_high, lim_mod, lim_low;

    position_t positions_pending[$];
    risk_t     risks_expected[$];
    int        errors;
    int        cycles;
    bit        quiet;
    bit        hold_sender;
    int        send_gap;
    int        take_gap;

    function automatic risk_t predict_risk(position_t p);
        risk_t       r;
        longint      sx;
        longint      sy;
        int unsigned sq;
        int unsigned root;
        int unsigned bitv;
        longint      num;
        longint      den;
        longint      q;
        sx = p.lateral_offset;
        sy = p.forward_depth;
        r.vehicle_stopped = 1'b0;
        if (vspeed == 0) begin
            r.vehicle_stopped = 1'b1;
            r.remaining_time  = TIME_MAX;
            r.risk_class      = RISK_NONE;
        end else if (friction == 0) begin
            r.remaining_time = TIME_MIN;
            r.risk_class     = RISK_CRITICAL;
        end else begin
            sq   = int'(sx * sx) + int'(sy * sy);
            root = 0;
            bitv = 32'h4000_0000;
            while (bitv > sq) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (sq >= root + bitv) begin
                    sq   = sq - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            num = ((longint'(root) - ped_speed * horizon) * 158922 * friction
                   - 625 * vspeed * vspeed) * 4608;
            den = 158922 * friction * 5 * vspeed;
            q = num / den;
            if ((num % den) != 0 && num < 0) q = q - 1;
            if (q > 8388607) q = 8388607;
            if (q < -8388608) q = -8388608;
            r.remaining_time = q[23:0];
            if (q < 0) r.risk_class = RISK_CRITICAL;
            else if (q < lim_high) r.risk_class = RISK_HIGH;
            else if (q < lim_mod) r.risk_class = RISK_MODERATE;
            else if (q < lim_low) r.risk_class = RISK_LOW;
            else r.risk_class = RISK_NONE;
        end
        return r;
    endfunction

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("[pedestrian_collision_risk_classifier_unit] ERROR");
            $finish;
        end
    end

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req.valid <= 1'b0;
            send_gap  <= 0;
        end else begin
            if (req.valid && req.ready)
                risks_expected.push_back(predict_risk({req.lateral_offset, req.forward_depth}));
            if (!req.valid || req.ready) begin
                if (send_gap > 0) begin
                    send_gap  <= send_gap - 1;
                    req.valid <= 1'b0;
                end else if (positions_pending.size() > 0 && !hold_sender) begin
                    {req.lateral_offset, req.forward_depth} <= positions_pending.pop_front();
                    req.valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 16);
                end else begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rsp.ready <= 1'b0;
            take_gap  <= 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (risks_expected.size() == 0) begin
                    $display("%0t unexpected beat: got %0d/%0d/%0d", $realtime,
                             rsp.remaining_time, rsp.risk_class, rsp.vehicle_stopped);
                    errors <= errors + 1;
                end else begin
                    risk_t e;
                    e = risks_expected.pop_front();
                    if (e.remaining_time !== rsp.remaining_time
                        || e.risk_class !== rsp.risk_class
                        || e.vehicle_stopped !== rsp.vehicle_stopped) begin
                        $display("%0t mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 $realtime, e.remaining_time, e.risk_class,
                                 e.vehicle_stopped, rsp.remaining_time,
                                 rsp.risk_class, rsp.vehicle_stopped);
                        errors <= errors + 1;
                    end
                end
            end
            if (take_gap > 0) begin
                take_gap  <= take_gap - 1;
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    take_gap <= $urandom_range(1, 16);
            end
        end
    end

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CfgDataW-1:0];
        case (idx)
            REG_VEHICLE_SPEED:    vspeed    = val & 16'hFFFF;
            REG_ROAD_FRICTION:    friction  = val & 10'h3FF;
            REG_PEDESTRIAN_SPEED: ped_speed = val & 12'hFFF;
            REG_TIME_HORIZON:     horizon   = val & 8'hFF;
            REG_HIGH_LIMIT:       lim_high  = val & 16'hFFFF;
            REG_MODERATE_LIMIT:   lim_mod   = val & 16'hFFFF;
            REG_LOW_LIMIT:        lim_low   = val & 16'hFFFF;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_settings(input int unsigned s, input int unsigned f,
                                  input int unsigned ps, input int unsigned th,
                                  input int unsigned hl, input int unsigned ml,
                                  input int unsigned ll);
        @(posedge clk);
        write_reg(REG_VEHICLE_SPEED, s);
        write_reg(REG_ROAD_FRICTION, f);
        write_reg(REG_PEDESTRIAN_SPEED, ps);
        write_reg(REG_TIME_HORIZON, th);
        write_reg(REG_HIGH_LIMIT, hl);
        write_reg(REG_MODERATE_LIMIT, ml);
        write_reg(REG_LOW_LIMIT, ll);
        cfg_we <= 1'b0;
        repeat (4) @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        while (positions_pending.size() > 0 || req.valid || risks_expected.size() > 0)
            @(negedge clk);
        repeat (LatencyWait) @(posedge clk);
    endtask

    task automatic push_pos(input int x, input int y);
        position_t p;
        p.lateral_offset = x[15:0];
        p.forward_depth  = y[15:0];
        positions_pending.push_back(p);
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0:       push_pos($urandom, $urandom);
                1:       push_pos($urandom_range(0, 2047) - 1024, $urandom_range(0, 8191));
                default: push_pos($urandom_range(0, 16383) - 8192,
                                  $urandom_range(0, 32767) - 16384);
            endcase
        end
    endtask

    initial
    begin
        int unsigned a;
        int unsigned b;
        int unsigned c;
        int unsigned t;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        req.valid = 1'b0;
        req.lateral_offset = '0;
        req.forward_depth  = '0;
        rsp.ready = 1'b0;
        errors    = 0;
        cycles    = 0;
        quiet     = 1'b0;
        hold_sender = 1'b0;
        vspeed = 12800; friction = 179; ped_speed = 0; horizon = 0;
        lim_high = 128; lim_mod = 256; lim_low = 384;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // defaults, field extremes
        push_pos(0, 0);
        push_pos(-32768, -32768);
        push_pos(32767, 32767);
        push_pos(-32768, 32767);
        push_pos(32767, -32768);
        push_pos(0, 1024);
        push_pos(0, 2560);
        push_pos(-1, -1);
        drain();

        // out-of-range index must not disturb settings
        @(posedge clk);
        write_reg(REG_UNUSED, 16'hFFFF);
        cfg_we <= 1'b0;
        repeat (4) @(posedge clk);
        push_pos(0, 4000);
        push_pos(100, 8000);
        drain();

        // vehicle stopped, then zero friction
        apply_settings(0, 0, 2559, 255, 0, 65535, 65535);
        push_pos(0, 0);
        push_pos(32767, -32768);
        drain();
        apply_settings(12800, 0, 0, 0, 128, 256, 384);
        push_pos(0, 0);
        push_pos(32767, 32767);
        drain();

        // extreme speed and friction, large travel, unordered limits
        apply_settings(65535, 1, 2559, 255, 65535, 0, 65535);
        push_pos(-32768, -32768);
        push_pos(0, 0);
        drain();
        apply_settings(1, 1023, 0, 0, 65535, 100, 50);
        push_pos(32767, 32767);
        push_pos(0, 1);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            a = $urandom_range(0, 1536);
            b = $urandom_range(0, 1536);
            c = $urandom_range(0, 1536);
            if (a > b) begin t = a; a = b; b = t; end
            if (b > c) begin t = b; b = c; c = t; end
            if (a > b) begin t = a; a = b; b = t; end
            if (ph == 4) begin
                a = $urandom_range(0, 65535);
                b = $urandom_range(0, 65535);
                c = $urandom_range(0, 65535);
            end
            apply_settings(ph == 6 ? 0 : $urandom_range(1280, 38400),
                           ph == 7 ? 0 : $urandom_range(1, 1023),
                           ph % 3 == 0 ? 0 : $urandom_range(0, 2559),
                           ph % 3 == 0 ? 0 : $urandom_range(0, 3),
                           a, b, c);
            if (ph == 8) quiet = 1'b1;
            if (ph == 2) begin
                push_random(100);
                @(negedge clk);
                while (positions_pending.size() > 50) @(negedge clk);
                hold_sender = 1'b1;
                while (risks_expected.size() > 0 || req.valid) @(negedge clk);
                hold_sender = 1'b0;
                push_random(100);
            end else begin
                push_random(ph == 6 || ph == 7 ? 40 : 260);
            end
            drain();
        end

        if (errors == 0) begin
            $display("[pedestrian_collision_risk_classifier_unit] OK");
        end else begin
            $display("[pedestrian_collision_risk_classifier_unit] ERROR");
        end
        $finish;
    end
endmodule
